>>> design/newmark_beta_3dof_integrator_defines.svh
// Assertion macros for the Newmark-beta integrator.
// Used by the top level; depends on signals named clk and rst in scope.
`ifndef NEWMARK_BETA_3DOF_INTEGRATOR_DEFINES_SVH
`define NEWMARK_BETA_3DOF_INTEGRATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NMB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/nmb_pkg.sv
// Shared types, constants, microprogram and saturating helpers for the
// Newmark-beta integrator. No dependencies.
package nmb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAMMA_Q16 = 32768;
  localparam int BETA_Q16  = 16384;

  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MASS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K_ROT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C_ROT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd7;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [31:0] MASS_RESET = 32'd65536;
  localparam logic [31:0] STEP_RESET = 32'd655;

  localparam longint INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint INT64_MIN = 64'sh8000_0000_0000_0000;

  // Method constants, rescaled to FRAC_BITS and derived at elaboration.
  localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
  localparam longint GM     = (longint'(GAMMA_Q16) << FRAC_BITS) / 65536;
  localparam longint BT     = (longint'(BETA_Q16) << FRAC_BITS) / 65536;
  localparam longint IB     = (BT == 0) ? INT64_MAX : (ONE_FX * ONE_FX) / BT;
  localparam logic [127:0] R_WIDE = (128'(GM) * 128'(IB)) >> FRAC_BITS;
  localparam longint R_FX   = (R_WIDE > 128'(INT64_MAX)) ? INT64_MAX
                                                          : longint'(R_WIDE[63:0]);
  localparam longint A3_FX  = IB / 2 - ONE_FX;
  localparam longint A4_FX  = R_FX - ONE_FX;
  localparam longint HRM1   = R_FX / 2 - ONE_FX;

  typedef enum logic [2:0] {OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef enum logic [4:0] {
    S_T0, S_T1, S_T2, S_T3, S_T4,
    S_A0, S_A1, S_A2, S_A5,
    S_IB, S_R, S_A3, S_A4, S_HRM1,
    S_MASS, S_DT, S_K, S_C,
    S_POS, S_VEL, S_ACC, S_FORCE, S_IPOS, S_IVEL
  } src_t;

  typedef enum logic [3:0] {
    D_T0, D_T1, D_T2, D_T3, D_T4,
    D_A0, D_A1, D_A2, D_A5,
    D_POS, D_VEL, D_ACC
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t d;
    logic sat;
    logic last;
  } instr_t;

  typedef struct packed {
    logic       load;
    logic       advance;
    logic       issue;
    instr_t     instr;
    logic [1:0] axis;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  localparam int PROG_LEN   = 43;
  localparam int PC_W       = $clog2(PROG_LEN);
  localparam int STEP_AXIS  = 4;
  localparam int START_AXIS = 36;

  localparam instr_t PROG [PROG_LEN] = '{
    // step coefficients
    '{OP_DIV, S_IB,    S_DT,   D_A2,  1'b0, 1'b0},
    '{OP_DIV, S_A2,    S_DT,   D_A0,  1'b0, 1'b0},
    '{OP_DIV, S_R,     S_DT,   D_A1,  1'b0, 1'b0},
    '{OP_MUL, S_DT,    S_HRM1, D_A5,  1'b0, 1'b0},
    // step, per axis
    '{OP_MUL, S_A0,    S_POS,  D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_A2,    S_VEL,  D_T1,  1'b0, 1'b0},
    '{OP_ADD, S_T0,    S_T1,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_A3,    S_ACC,  D_T1,  1'b0, 1'b0},
    '{OP_ADD, S_T0,    S_T1,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_A1,    S_POS,  D_T1,  1'b0, 1'b0},
    '{OP_MUL, S_A4,    S_VEL,  D_T2,  1'b0, 1'b0},
    '{OP_ADD, S_T1,    S_T2,   D_T1,  1'b0, 1'b0},
    '{OP_MUL, S_A5,    S_ACC,  D_T2,  1'b0, 1'b0},
    '{OP_ADD, S_T1,    S_T2,   D_T1,  1'b0, 1'b0},
    '{OP_MUL, S_MASS,  S_T0,   D_T0,  1'b0, 1'b0},
    '{OP_ADD, S_FORCE, S_T0,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_C,     S_T1,   D_T1,  1'b0, 1'b0},
    '{OP_ADD, S_T0,    S_T1,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_MASS,  S_A0,   D_T1,  1'b0, 1'b0},
    '{OP_ADD, S_T1,    S_K,    D_T1,  1'b0, 1'b0},
    '{OP_MUL, S_C,     S_A1,   D_T2,  1'b0, 1'b0},
    '{OP_ADD, S_T1,    S_T2,   D_T1,  1'b0, 1'b0},
    '{OP_DIV, S_T0,    S_T1,   D_T3,  1'b1, 1'b0},
    '{OP_SUB, S_T3,    S_POS,  D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_A1,    S_T0,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_A4,    S_VEL,  D_T1,  1'b0, 1'b0},
    '{OP_SUB, S_T0,    S_T1,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_A5,    S_ACC,  D_T1,  1'b0, 1'b0},
    '{OP_SUB, S_T0,    S_T1,   D_T4,  1'b1, 1'b0},
    '{OP_MOV, S_T3,    S_T3,   D_POS, 1'b1, 1'b0},
    '{OP_MOV, S_T4,    S_T4,   D_VEL, 1'b1, 1'b0},
    '{OP_MUL, S_K,     S_POS,  D_T0,  1'b0, 1'b0},
    '{OP_SUB, S_FORCE, S_T0,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_C,     S_VEL,  D_T1,  1'b0, 1'b0},
    '{OP_SUB, S_T0,    S_T1,   D_T0,  1'b0, 1'b0},
    '{OP_DIV, S_T0,    S_MASS, D_ACC, 1'b1, 1'b1},
    // start, per axis
    '{OP_MOV, S_IPOS,  S_IPOS, D_POS, 1'b1, 1'b0},
    '{OP_MOV, S_IVEL,  S_IVEL, D_VEL, 1'b1, 1'b0},
    '{OP_MUL, S_K,     S_POS,  D_T0,  1'b0, 1'b0},
    '{OP_SUB, S_FORCE, S_T0,   D_T0,  1'b0, 1'b0},
    '{OP_MUL, S_C,     S_VEL,  D_T1,  1'b0, 1'b0},
    '{OP_SUB, S_T0,    S_T1,   D_T0,  1'b0, 1'b0},
    '{OP_DIV, S_T0,    S_MASS, D_ACC, 1'b1, 1'b1}
  };

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? INT64_MIN : INT64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? INT64_MIN : INT64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (a < -64'sd2147483648) return 32'sh8000_0000;
    return a[31:0];
  endfunction

endpackage

>>> design/newmark_beta_3dof_integrator.sv
// Newmark-beta integrator, three damped spring-mass axes sharing one mass.
// Operations: add, subtract, move, multiply and divide (bit-serial restoring divider, one
// quotient bit a cycle; the bit loop is skipped for a zero divisor or when the quotient saturates at once).
// Throughput: one item at a time; the next input transfer can come once the result is posted.
// Reset (rst, synchronous): registers to defaults, state and step count to zero.
`include "newmark_beta_3dof_integrator_defines.svh"
module newmark_beta_3dof_integrator (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic signed [31:0]    init_pos_x,
  input  logic signed [31:0]    init_pos_y,
  input  logic signed [31:0]    init_pos_rot,
  input  logic signed [31:0]    init_vel_x,
  input  logic signed [31:0]    init_vel_y,
  input  logic signed [31:0]    init_vel_rot,
  input  logic signed [31:0]    force_x,
  input  logic signed [31:0]    force_y,
  input  logic signed [31:0]    moment_rot,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           step_index,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [31:0]    pos_rot,
  output logic signed [31:0]    vel_x,
  output logic signed [31:0]    vel_y,
  output logic signed [31:0]    vel_rot,
  output logic signed [31:0]    acc_x,
  output logic signed [31:0]    acc_y,
  output logic signed [31:0]    acc_rot,
  // configuration writes
  input  logic                  cfg_wen,
  input  logic [nmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]           cfg_data
);

  // Controller sequences the microprogram; datapath does every operation.
  // Depends on nmb_pkg, nmb_ctrl, nmb_datapath and the assertion macro header.
  nmb_pkg::cmd_t    cmd;
  nmb_pkg::status_t status;

  // The controller takes a transfer only when idle, then runs the
  // coefficient block (step items only) and the per-axis block three times.
  nmb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the item's fields from the accepting edge on, and
  // copies the state into the output register on publish, so a result
  // waiting for its transfer does not block the next item.
  nmb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .init_pos_x   (init_pos_x),
    .init_pos_y   (init_pos_y),
    .init_pos_rot (init_pos_rot),
    .init_vel_x   (init_vel_x),
    .init_vel_y   (init_vel_y),
    .init_vel_rot (init_vel_rot),
    .force_x      (force_x),
    .force_y      (force_y),
    .moment_rot   (moment_rot),
    .step_index   (step_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_rot      (pos_rot),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_rot      (vel_rot),
    .acc_x        (acc_x),
    .acc_y        (acc_y),
    .acc_rot      (acc_rot)
  );

  // Busy right after a transfer in.
  `NMB_ASSERT_NEXT(a_busy_after_load, in_valid && in_ready, !in_ready, "ready after accept")
  // No operation completes while the sequencer is idle.
  `NMB_ASSERT_SAME(a_done_only_busy, status.done, !in_ready, "done while idle")
  // Never overwrite a result that has not been transferred.
  `NMB_ASSERT_SAME(a_no_overwrite, cmd.publish, !out_valid || out_ready, "result overwritten")

endmodule

>>> design/nmb_muldiv.sv
// Sequential fixed-point multiply (a*b >> FRAC_BITS) and divide
// (a << FRAC_BITS / b), exact, truncated toward zero, saturated. Uses nmb_pkg.
module nmb_muldiv (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               is_div,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] result,
  output logic               done
);

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_MUL_FIN, M_DIV_PREP, M_DIV, M_FIN} phase_t;

  phase_t       phase;
  logic [5:0]   cnt;
  logic         neg;
  logic [63:0]  ua, ub, q, rem, lo;
  logic [127:0] acc;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  trial;
  logic [63:0]  lim, qs, hi;

  always_comb begin
    pa = cnt[1] ? ua[63:32] : ua[31:0];
    pb = cnt[0] ? ub[63:32] : ub[31:0];
    pp = pa * pb;
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    trial = {rem, lo[63]};
    hi    = ua >> (64 - nmb_pkg::FRAC_BITS);
    lim   = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    qs    = (q > lim) ? lim : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == M_FIN);
      unique case (phase)
        M_IDLE: begin
          if (start) begin
            neg   <= a[63] ^ b[63];
            ua    <= a[63] ? (~a + 64'd1) : a;
            ub    <= b[63] ? (~b + 64'd1) : b;
            acc   <= '0;
            cnt   <= '0;
            phase <= is_div ? M_DIV_PREP : M_MUL;
          end
        end
        M_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) phase <= M_MUL_FIN;
        end
        M_MUL_FIN: begin
          q     <= (|acc[127:64+nmb_pkg::FRAC_BITS]) ? '1 : acc[nmb_pkg::FRAC_BITS +: 64];
          phase <= M_FIN;
        end
        M_DIV_PREP: begin
          // zero divisor: zero for a zero dividend, limit otherwise
          if (ub == '0) begin
            q     <= (ua == '0) ? '0 : '1;
            phase <= M_FIN;
          end else if (hi >= ub) begin
            q     <= '1;
            phase <= M_FIN;
          end else begin
            rem   <= hi;
            lo    <= ua << nmb_pkg::FRAC_BITS;
            cnt   <= '0;
            phase <= M_DIV;
          end
        end
        M_DIV: begin
          if (trial >= {1'b0, ub}) begin
            rem <= 64'(trial - {1'b0, ub});
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            q   <= {q[62:0], 1'b0};
          end
          lo  <= {lo[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) phase <= M_FIN;
        end
        M_FIN: begin
          result <= neg ? (~qs + 64'd1) : qs;
          phase  <= M_IDLE;
        end
        default: phase <= M_IDLE;
      endcase
    end
  end

endmodule

>>> design/nmb_datapath.sv
// Datapath: configuration registers, axis state, temporaries, operand
// selection, saturating add/sub and the shared multiply/divide unit. Uses nmb_pkg.
module nmb_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  nmb_pkg::cmd_t         cmd,
  output nmb_pkg::status_t      status,
  input  logic                  cfg_wen,
  input  logic [nmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic signed [31:0]    init_pos_x,
  input  logic signed [31:0]    init_pos_y,
  input  logic signed [31:0]    init_pos_rot,
  input  logic signed [31:0]    init_vel_x,
  input  logic signed [31:0]    init_vel_y,
  input  logic signed [31:0]    init_vel_rot,
  input  logic signed [31:0]    force_x,
  input  logic signed [31:0]    force_y,
  input  logic signed [31:0]    moment_rot,
  output logic [31:0]           step_index,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [31:0]    pos_rot,
  output logic signed [31:0]    vel_x,
  output logic signed [31:0]    vel_y,
  output logic signed [31:0]    vel_rot,
  output logic signed [31:0]    acc_x,
  output logic signed [31:0]    acc_y,
  output logic signed [31:0]    acc_rot
);

  logic [31:0]        mass, step_size;
  logic [30:0]        stiff [nmb_pkg::NUM_AXES];
  logic [30:0]        damp  [nmb_pkg::NUM_AXES];
  logic signed [31:0] pos   [nmb_pkg::NUM_AXES];
  logic signed [31:0] vel   [nmb_pkg::NUM_AXES];
  logic signed [31:0] acc   [nmb_pkg::NUM_AXES];
  logic signed [31:0] frc   [nmb_pkg::NUM_AXES];
  logic signed [31:0] ipos  [nmb_pkg::NUM_AXES];
  logic signed [31:0] ivel  [nmb_pkg::NUM_AXES];
  logic [31:0]        step_count;

  logic signed [63:0] t0, t1, t2, t3, t4, a0, a1, a2, a5;
  logic signed [63:0] opa, opb, alu_res, md_res, wval, tval;
  logic signed [31:0] store32;
  logic               alu_done, md_done;
  nmb_pkg::dst_t      w_dst;
  logic               w_sat;

  function automatic logic signed [63:0] operand(input nmb_pkg::src_t s);
    logic [1:0] x;
    x = cmd.axis;
    case (s)
      nmb_pkg::S_T0:    return t0;
      nmb_pkg::S_T1:    return t1;
      nmb_pkg::S_T2:    return t2;
      nmb_pkg::S_T3:    return t3;
      nmb_pkg::S_T4:    return t4;
      nmb_pkg::S_A0:    return a0;
      nmb_pkg::S_A1:    return a1;
      nmb_pkg::S_A2:    return a2;
      nmb_pkg::S_A5:    return a5;
      nmb_pkg::S_IB:    return nmb_pkg::IB;
      nmb_pkg::S_R:     return nmb_pkg::R_FX;
      nmb_pkg::S_A3:    return nmb_pkg::A3_FX;
      nmb_pkg::S_A4:    return nmb_pkg::A4_FX;
      nmb_pkg::S_HRM1:  return nmb_pkg::HRM1;
      nmb_pkg::S_MASS:  return {32'd0, mass};
      nmb_pkg::S_DT:    return {32'd0, step_size};
      nmb_pkg::S_K:     return {33'd0, stiff[x]};
      nmb_pkg::S_C:     return {33'd0, damp[x]};
      nmb_pkg::S_POS:   return 64'(pos[x]);
      nmb_pkg::S_VEL:   return 64'(vel[x]);
      nmb_pkg::S_ACC:   return 64'(acc[x]);
      nmb_pkg::S_FORCE: return 64'(frc[x]);
      nmb_pkg::S_IPOS:  return 64'(ipos[x]);
      nmb_pkg::S_IVEL:  return 64'(ivel[x]);
      default:          return '0;
    endcase
  endfunction

  always_comb begin
    opa     = operand(cmd.instr.a);
    opb     = operand(cmd.instr.b);
    wval    = alu_done ? alu_res : md_res;
    store32 = nmb_pkg::sat32(wval);
    tval    = w_sat ? 64'(store32) : wval;
  end

  assign status.done = alu_done | md_done;

  nmb_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.issue && (cmd.instr.op == nmb_pkg::OP_MUL ||
                           cmd.instr.op == nmb_pkg::OP_DIV)),
    .is_div (cmd.instr.op == nmb_pkg::OP_DIV),
    .a      (opa),
    .b      (opb),
    .result (md_res),
    .done   (md_done)
  );

  // issue: latch destination, register the short ops' result and their done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      alu_done <= 1'b0;
    end else begin
      alu_done <= cmd.issue && (cmd.instr.op == nmb_pkg::OP_MOV ||
                                cmd.instr.op == nmb_pkg::OP_ADD ||
                                cmd.instr.op == nmb_pkg::OP_SUB);
    end
    if (cmd.issue) begin
      w_dst <= cmd.instr.d;
      w_sat <= cmd.instr.sat;
      case (cmd.instr.op)
        nmb_pkg::OP_ADD: alu_res <= nmb_pkg::sat_add(opa, opb);
        nmb_pkg::OP_SUB: alu_res <= nmb_pkg::sat_sub(opa, opb);
        default:         alu_res <= opa;
      endcase
    end
  end

  // configuration, axis state and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      mass       <= nmb_pkg::MASS_RESET;
      step_size  <= nmb_pkg::STEP_RESET;
      step_count <= '0;
      for (int i = 0; i < nmb_pkg::NUM_AXES; i++) begin
        stiff[i] <= '0;
        damp[i]  <= '0;
        pos[i]   <= '0;
        vel[i]   <= '0;
        acc[i]   <= '0;
      end
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          nmb_pkg::REG_MASS:  mass      <= cfg_data;
          nmb_pkg::REG_K_X:   stiff[0]  <= cfg_data[30:0];
          nmb_pkg::REG_K_Y:   stiff[1]  <= cfg_data[30:0];
          nmb_pkg::REG_K_ROT: stiff[2]  <= cfg_data[30:0];
          nmb_pkg::REG_C_X:   damp[0]   <= cfg_data[30:0];
          nmb_pkg::REG_C_Y:   damp[1]   <= cfg_data[30:0];
          nmb_pkg::REG_C_ROT: damp[2]   <= cfg_data[30:0];
          nmb_pkg::REG_STEP:  step_size <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) step_count <= cmd.advance ? step_count + 32'd1 : '0;
      if (status.done) begin
        case (w_dst)
          nmb_pkg::D_POS: pos[cmd.axis] <= store32;
          nmb_pkg::D_VEL: vel[cmd.axis] <= store32;
          nmb_pkg::D_ACC: acc[cmd.axis] <= store32;
          default: ;
        endcase
      end
    end
  end

  // temporaries and coefficients
  always_ff @(posedge clk) begin
    if (status.done) begin
      case (w_dst)
        nmb_pkg::D_T0: t0 <= tval;
        nmb_pkg::D_T1: t1 <= tval;
        nmb_pkg::D_T2: t2 <= tval;
        nmb_pkg::D_T3: t3 <= tval;
        nmb_pkg::D_T4: t4 <= tval;
        nmb_pkg::D_A0: a0 <= tval;
        nmb_pkg::D_A1: a1 <= tval;
        nmb_pkg::D_A2: a2 <= tval;
        nmb_pkg::D_A5: a5 <= tval;
        default: ;
      endcase
    end
  end

  // hold the item's fields for the whole computation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ipos[0] <= init_pos_x;
      ipos[1] <= init_pos_y;
      ipos[2] <= init_pos_rot;
      ivel[0] <= init_vel_x;
      ivel[1] <= init_vel_y;
      ivel[2] <= init_vel_rot;
      frc[0]  <= force_x;
      frc[1]  <= force_y;
      frc[2]  <= moment_rot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      step_index <= step_count;
      pos_x      <= pos[0];
      pos_y      <= pos[1];
      pos_rot    <= pos[2];
      vel_x      <= vel[0];
      vel_y      <= vel[1];
      vel_rot    <= vel[2];
      acc_x      <= acc[0];
      acc_y      <= acc[1];
      acc_rot    <= acc[2];
    end
  end

endmodule

>>> design/nmb_ctrl.sv
// Controller: input/output handshake and the microprogram sequencer that
// walks nmb_pkg::PROG once for coefficients (step items only) and once per axis. Uses nmb_pkg.
module nmb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  output logic             out_valid,
  input  logic             out_ready,
  output nmb_pkg::cmd_t    cmd,
  input  nmb_pkg::status_t status
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_t;

  state_t                     state;
  logic [nmb_pkg::PC_W-1:0]   pc, loop_pc;
  logic [1:0]                 axis;
  logic                       accept;
  nmb_pkg::instr_t            instr;

  always_comb begin
    in_ready     = (state == S_IDLE);
    accept       = in_valid && in_ready;
    instr        = nmb_pkg::PROG[pc];
    cmd.load     = accept;
    cmd.advance  = (action == nmb_pkg::ACT_STEP);
    cmd.issue    = (state == S_ISSUE);
    cmd.instr    = instr;
    cmd.axis     = axis;
    cmd.publish  = (state == S_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      loop_pc   <= '0;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            axis  <= '0;
            state <= S_ISSUE;
            if (action == nmb_pkg::ACT_STEP) begin
              pc      <= '0;
              loop_pc <= nmb_pkg::PC_W'(nmb_pkg::STEP_AXIS);
            end else begin
              pc      <= nmb_pkg::PC_W'(nmb_pkg::START_AXIS);
              loop_pc <= nmb_pkg::PC_W'(nmb_pkg::START_AXIS);
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (status.done) begin
            if (instr.last && axis == 2'(nmb_pkg::NUM_AXES - 1)) begin
              state <= S_FINISH;
            end else if (instr.last) begin
              axis  <= axis + 2'd1;
              pc    <= loop_pc;
              state <= S_ISSUE;
            end else begin
              pc    <= pc + nmb_pkg::PC_W'(1);
              state <= S_ISSUE;
            end
          end
        end
        S_FINISH: if (cmd.publish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
